@@ rtl/core/skyp_pkg.sv @@
`default_nettype none
package skyp_pkg;

    localparam int SEG_MAX = 256;
    localparam int DIM_W = 13;
    localparam int POS_W = 12;
    localparam logic [DIM_W-1:0] BIN_RESET = 13'd1024;

    localparam logic [1:0] REG_BIN_WIDTH = 2'd0;
    localparam logic [1:0] REG_BIN_HEIGHT = 2'd1;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] level;
        logic [DIM_W-1:0] span;
    } seg_t;

endpackage
`default_nettype wire

@@ rtl/core/skyline_rect_packer_top.sv @@
// Skyline bottom-left rectangle packer.
// s_ channel: one rectangle request per transfer. m_ channel: one result per
// request (placed flag and bottom-left position, zeros when rejected).
// cfg channel: writes bin_width (index 0) or bin_height (index 1); always
// ready, to be used only while the block is idle. Writes keep the skyline.
// A request against n segments first walks each start segment over the
// segments its width covers and scores each start that fits, then rebuilds
// the list when placed. The single read port of the segment store sets the
// pace.
// The list is rebuilt into a second store bank in one streaming pass that
// inserts, trims and merges, then the banks swap.
// s_tready is high only when idle. A finished result waits in the output
// register while the receiver stalls; the next request may be taken then,
// and its result waits until the previous one is transferred.
// Reset: skyline is one segment of level 0 spanning 1024, bins 1024 x 1024.
`default_nettype none
module skyline_rect_packer_top #(
    parameter int MAX_SEGMENTS = skyp_pkg::SEG_MAX
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // rect_width[12:0], rect_height[25:13], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // placed[0], pos_x[12:1], pos_y[24:13], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW = skyp_pkg::DIM_W;
    localparam int PW = skyp_pkg::POS_W;
    localparam int SW = $bits(skyp_pkg::seg_t);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SCAN_RD = 4'd1;
    localparam logic [3:0] ST_HEAD    = 4'd2;
    localparam logic [3:0] ST_WALK    = 4'd3;
    localparam logic [3:0] ST_EVAL    = 4'd4;
    localparam logic [3:0] ST_B_RD    = 4'd5;
    localparam logic [3:0] ST_B_PROC  = 4'd6;
    localparam logic [3:0] ST_DONE    = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [DW-1:0] bin_w_reg, bin_w_next, bin_h_reg, bin_h_next;
    logic [DW-1:0] w_reg, w_next, h_reg, h_next;
    logic [CW-1:0] count_reg, count_next;
    logic bank_reg, bank_next, init_reg, init_next;
    logic [CW-1:0] i_reg, i_next, k_reg, k_next;
    logic [DW-1:0] y_reg, y_next, span_i_reg, span_i_next, x_i_reg, x_i_next;
    logic signed [DW+1:0] left_reg, left_next;
    logic found_reg, found_next;
    logic [DW-1:0] best_top_reg, best_top_next, best_span_reg, best_span_next;
    logic [DW-1:0] best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic [CW-1:0] best_i_reg, best_i_next;
    logic [CW-1:0] j_reg, j_next, wcnt_reg, wcnt_next;
    logic new_done_reg, new_done_next, trim_reg, trim_next, has_pend_reg, has_pend_next;
    skyp_pkg::seg_t pend_reg, pend_next;
    logic res_placed_reg, res_placed_next;
    logic [PW-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    logic [AW-1:0] raddr;
    logic we;
    logic [AW-1:0] waddr;
    skyp_pkg::seg_t wseg, rd_seg, feed_seg;
    logic feed_en;
    logic [SW-1:0] rdata0, rdata1;

    logic [DW:0] x_plus_w, y_plus_h, ymax_plus_h, top_full, end_pos, shrink;
    logic [DW-1:0] ymax;
    logic signed [DW+1:0] left_head, left_walk;

    skyp_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_bank0 (
        .aclk (aclk), .we (we & bank_reg), .waddr (waddr), .wdata (wseg),
        .raddr (raddr), .rdata (rdata0)
    );

    skyp_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_bank1 (
        .aclk (aclk), .we (we & ~bank_reg), .waddr (waddr), .wdata (wseg),
        .raddr (raddr), .rdata (rdata1)
    );

    always_comb begin
        if (init_reg) begin
            rd_seg = '{x: '0, level: '0, span: skyp_pkg::BIN_RESET};
        end else if (bank_reg) begin
            rd_seg = rdata1;
        end else begin
            rd_seg = rdata0;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign x_plus_w    = {1'b0, rd_seg.x} + {1'b0, w_reg};
    assign y_plus_h    = {1'b0, rd_seg.level} + {1'b0, h_reg};
    assign left_head   = $signed({2'b00, w_reg}) - $signed({2'b00, rd_seg.span});
    assign ymax        = (rd_seg.level > y_reg) ? rd_seg.level : y_reg;
    assign ymax_plus_h = {1'b0, ymax} + {1'b0, h_reg};
    assign left_walk   = left_reg - $signed({2'b00, rd_seg.span});
    assign top_full    = {1'b0, y_reg} + {1'b0, h_reg};
    assign end_pos     = {1'b0, best_x_reg} + {1'b0, w_reg};
    assign shrink      = end_pos - {1'b0, rd_seg.x};

    always_comb begin
        state_next = state_reg;
        bin_w_next = bin_w_reg;
        bin_h_next = bin_h_reg;
        w_next = w_reg;
        h_next = h_reg;
        count_next = count_reg;
        bank_next = bank_reg;
        init_next = init_reg;
        i_next = i_reg;
        k_next = k_reg;
        y_next = y_reg;
        span_i_next = span_i_reg;
        x_i_next = x_i_reg;
        left_next = left_reg;
        found_next = found_reg;
        best_top_next = best_top_reg;
        best_span_next = best_span_reg;
        best_x_next = best_x_reg;
        best_y_next = best_y_reg;
        best_i_next = best_i_reg;
        j_next = j_reg;
        wcnt_next = wcnt_reg;
        new_done_next = new_done_reg;
        trim_next = trim_reg;
        has_pend_next = has_pend_reg;
        pend_next = pend_reg;
        res_placed_next = res_placed_reg;
        res_x_next = res_x_reg;
        res_y_next = res_y_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        raddr = i_reg[AW-1:0];
        we = 1'b0;
        waddr = wcnt_reg[AW-1:0];
        wseg = pend_reg;
        feed_en = 1'b0;
        feed_seg = rd_seg;

        if (cfg_valid) begin
            if (cfg_index == skyp_pkg::REG_BIN_WIDTH) begin
                bin_w_next = cfg_data;
            end else if (cfg_index == skyp_pkg::REG_BIN_HEIGHT) begin
                bin_h_next = cfg_data;
            end
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    w_next = s_tdata[12:0];
                    h_next = s_tdata[25:13];
                    i_next = '0;
                    found_next = 1'b0;
                    if (s_tdata[12:0] == '0 || s_tdata[25:13] == '0
                            || count_reg >= CW'(MAX_SEGMENTS)) begin
                        res_placed_next = 1'b0;
                        res_x_next = '0;
                        res_y_next = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (i_reg >= count_reg) begin
                    if (found_reg) begin
                        j_next = '0;
                        wcnt_next = '0;
                        new_done_next = 1'b0;
                        trim_next = 1'b0;
                        has_pend_next = 1'b0;
                        state_next = ST_B_RD;
                    end else begin
                        res_placed_next = 1'b0;
                        res_x_next = '0;
                        res_y_next = '0;
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                x_i_next = rd_seg.x;
                span_i_next = rd_seg.span;
                y_next = rd_seg.level;
                left_next = left_head;
                k_next = i_reg + 1'b1;
                if (x_plus_w > {1'b0, bin_w_reg} || y_plus_h > {1'b0, bin_h_reg}) begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end else if (left_head <= 0) begin
                    state_next = ST_EVAL;
                end else if (i_reg + 1'b1 >= count_reg) begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end else begin
                    raddr = k_next[AW-1:0];
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                y_next = ymax;
                left_next = left_walk;
                k_next = k_reg + 1'b1;
                if (ymax_plus_h > {1'b0, bin_h_reg}) begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end else if (left_walk <= 0) begin
                    state_next = ST_EVAL;
                end else if (k_reg + 1'b1 >= count_reg) begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end else begin
                    raddr = k_next[AW-1:0];
                end
            end
            ST_EVAL: begin
                if (!found_reg || top_full[DW-1:0] < best_top_reg
                        || (top_full[DW-1:0] == best_top_reg && span_i_reg < best_span_reg)) begin
                    found_next = 1'b1;
                    best_top_next = top_full[DW-1:0];
                    best_span_next = span_i_reg;
                    best_i_next = i_reg;
                    best_x_next = x_i_reg;
                    best_y_next = y_reg;
                end
                i_next = i_reg + 1'b1;
                state_next = ST_SCAN_RD;
            end
            ST_B_RD: begin
                raddr = j_reg[AW-1:0];
                if (!new_done_reg && j_reg == best_i_reg) begin
                    feed_en = 1'b1;
                    feed_seg = '{x: best_x_reg, level: best_top_reg, span: w_reg};
                    new_done_next = 1'b1;
                    trim_next = 1'b1;
                end else if (j_reg >= count_reg) begin
                    we = 1'b1;
                    count_next = wcnt_reg + 1'b1;
                    bank_next = ~bank_reg;
                    init_next = 1'b0;
                    res_placed_next = 1'b1;
                    res_x_next = best_x_reg[PW-1:0];
                    res_y_next = best_y_reg[PW-1:0];
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_B_PROC;
                end
            end
            ST_B_PROC: begin
                j_next = j_reg + 1'b1;
                state_next = ST_B_RD;
                if (trim_reg && {1'b0, rd_seg.x} < end_pos) begin
                    if ({1'b0, rd_seg.span} > shrink) begin
                        feed_en = 1'b1;
                        feed_seg = '{x: end_pos[DW-1:0], level: rd_seg.level,
                                     span: rd_seg.span - shrink[DW-1:0]};
                        trim_next = 1'b0;
                    end
                end else begin
                    feed_en = 1'b1;
                    trim_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {7'd0, res_y_reg, res_x_reg, res_placed_reg};
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (feed_en) begin
            if (has_pend_reg && feed_seg.level == pend_reg.level) begin
                pend_next.span = pend_reg.span + feed_seg.span;
            end else begin
                if (has_pend_reg) begin
                    we = 1'b1;
                    wcnt_next = wcnt_reg + 1'b1;
                end
                pend_next = feed_seg;
                has_pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bin_w_reg <= skyp_pkg::BIN_RESET;
            bin_h_reg <= skyp_pkg::BIN_RESET;
            count_reg <= CW'(1);
            bank_reg <= 1'b0;
            init_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            bin_w_reg <= bin_w_next;
            bin_h_reg <= bin_h_next;
            count_reg <= count_next;
            bank_reg <= bank_next;
            init_reg <= init_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        h_reg <= h_next;
        i_reg <= i_next;
        k_reg <= k_next;
        y_reg <= y_next;
        span_i_reg <= span_i_next;
        x_i_reg <= x_i_next;
        left_reg <= left_next;
        found_reg <= found_next;
        best_top_reg <= best_top_next;
        best_span_reg <= best_span_next;
        best_x_reg <= best_x_next;
        best_y_reg <= best_y_next;
        best_i_reg <= best_i_next;
        j_reg <= j_next;
        wcnt_reg <= wcnt_next;
        new_done_reg <= new_done_next;
        trim_reg <= trim_next;
        has_pend_reg <= has_pend_next;
        pend_reg <= pend_next;
        res_placed_reg <= res_placed_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count out of range");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted request did not start");

    a_build_wcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_B_PROC |-> wcnt_reg <= j_reg)
        else $error("rebuild write pointer ahead of read pointer");

    a_init_single: assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> count_reg == CW'(1))
        else $error("reset skyline with more than one segment");

endmodule
`default_nettype wire

@@ rtl/core/skyp_ram.sv @@
`default_nettype none
module skyp_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ sim/skyline_checker.sv @@
`timescale 1ns / 100ps
module skyline_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    output int               fails,
    output int               pending
);

    typedef struct packed {
        logic                       placed;
        logic [skyp_pkg::POS_W-1:0] x;
        logic [skyp_pkg::POS_W-1:0] y;
    } place_t;

    int     bin_w;
    int     bin_h;
    int     sky_x [skyp_pkg::SEG_MAX];
    int     sky_lvl [skyp_pkg::SEG_MAX];
    int     sky_span [skyp_pkg::SEG_MAX];
    int     sky_cnt;
    place_t placement_q[$];

    function automatic void sky_clear();
        bin_w = skyp_pkg::BIN_RESET;
        bin_h = skyp_pkg::BIN_RESET;
        for (int i = 0; i < skyp_pkg::SEG_MAX; i++) begin
            sky_x[i] = 0;
            sky_lvl[i] = 0;
            sky_span[i] = 0;
        end
        sky_span[0] = skyp_pkg::BIN_RESET;
        sky_cnt = 1;
    endfunction

    function automatic void sky_drop(int k);
        if (k >= sky_cnt) return;
        for (int i = k; i < sky_cnt - 1; i++) begin
            sky_x[i] = sky_x[i+1];
            sky_lvl[i] = sky_lvl[i+1];
            sky_span[i] = sky_span[i+1];
        end
        sky_cnt--;
    endfunction

    function automatic void sky_open(int k, int x, int lvl, int span);
        if (sky_cnt >= skyp_pkg::SEG_MAX || k > sky_cnt) return;
        for (int i = sky_cnt; i > k; i--) begin
            sky_x[i] = sky_x[i-1];
            sky_lvl[i] = sky_lvl[i-1];
            sky_span[i] = sky_span[i-1];
        end
        sky_x[k] = x & 'h1FFF;
        sky_lvl[k] = lvl & 'h1FFF;
        sky_span[k] = span & 'h1FFF;
        sky_cnt++;
    endfunction

    // resting level of a w x h rect whose left edge sits at segment idx
    function automatic bit rest_at(int idx, int w, int h, output int lvl);
        int left;
        int k;
        int y;
        left = w;
        k = idx;
        lvl = 0;
        if (sky_x[idx] + w > bin_w) return 0;
        y = sky_lvl[idx];
        while (left > 0) begin
            if (k >= sky_cnt) return 0;
            if (sky_lvl[k] > y) y = sky_lvl[k];
            if (y + h > bin_h) return 0;
            left -= sky_span[k];
            k++;
        end
        lvl = y;
        return 1;
    endfunction

    function automatic place_t place_rect(int w, int h);
        place_t r;
        bit     found;
        int     top, best_top, best_span, best_i, best_x, best_y, y, i, end_prev, shrink;
        r = '0;
        found = 0;
        best_top = 0;
        best_span = 0;
        best_i = 0;
        best_x = 0;
        best_y = 0;
        if (w == 0 || h == 0 || sky_cnt >= skyp_pkg::SEG_MAX || sky_cnt == 0) return r;
        for (i = 0; i < sky_cnt; i++) begin
            if (rest_at(i, w, h, y)) begin
                top = y + h;
                if (!found || top < best_top || (top == best_top && sky_span[i] < best_span)) begin
                    found = 1;
                    best_top = top;
                    best_span = sky_span[i];
                    best_i = i;
                    best_x = sky_x[i];
                    best_y = y;
                end
            end
        end
        if (!found) return r;
        sky_open(best_i, best_x, best_top, w);
        i = best_i + 1;
        while (i < sky_cnt) begin
            end_prev = sky_x[i-1] + sky_span[i-1];
            if (sky_x[i] >= end_prev) break;
            shrink = end_prev - sky_x[i];
            if (sky_span[i] <= shrink) begin
                sky_drop(i);
            end else begin
                sky_x[i] = (sky_x[i] + shrink) & 'h1FFF;
                sky_span[i] -= shrink;
                break;
            end
        end
        i = 0;
        while (i + 1 < sky_cnt) begin
            if (sky_lvl[i] == sky_lvl[i+1]) begin
                sky_span[i] = (sky_span[i] + sky_span[i+1]) & 'h1FFF;
                sky_drop(i + 1);
            end else begin
                i++;
            end
        end
        r.placed = 1'b1;
        r.x = best_x[skyp_pkg::POS_W-1:0];
        r.y = best_y[skyp_pkg::POS_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        place_t exp_r;
        place_t got;
        if (!aresetn) begin
            sky_clear();
            placement_q.delete();
            fails = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == skyp_pkg::REG_BIN_WIDTH) bin_w = cfg_data;
                else if (cfg_index == skyp_pkg::REG_BIN_HEIGHT) bin_h = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                got.placed = m_tdata[0];
                got.x = m_tdata[12:1];
                got.y = m_tdata[24:13];
                if (placement_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $realtime, m_tdata);
                    fails++;
                end else begin
                    exp_r = placement_q.pop_front();
                    if (got.placed !== exp_r.placed) begin
                        $display("%0t: placed exp %0d got %0d", $realtime, exp_r.placed,
                                 got.placed);
                        fails++;
                    end
                    if (got.x !== exp_r.x) begin
                        $display("%0t: pos_x exp %0d got %0d", $realtime, exp_r.x, got.x);
                        fails++;
                    end
                    if (got.y !== exp_r.y) begin
                        $display("%0t: pos_y exp %0d got %0d", $realtime, exp_r.y, got.y);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                placement_q = {placement_q, place_rect(s_tdata[12:0], s_tdata[25:13])};
        end
        pending = placement_q.size();
    end

endmodule

@@ sim/tb_skyline_rect_packer_top.sv @@
`timescale 1ns / 100ps
module tb_skyline_rect_packer_top;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    int          fails;
    int          pending;
    int          burst_left;
    int          cyc;

    skyline_rect_packer_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    skyline_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver stall pattern: rotates through four m_tready modes
    initial begin
        cyc = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            case ((cyc / 97) % 4)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 1) == 1);
                2: m_tready = ($urandom_range(0, 7) == 0);
                default: m_tready = ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_rect(int w, int h);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = {6'd0, h[12:0], w[12:0]};
        #1;
        while (!s_tready) begin
            @(negedge aclk);
            #1;
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val[12:0];
        #1;
        while (!cfg_ready) begin
            @(negedge aclk);
            #1;
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic int rand_dim();
        if ($urandom_range(0, 15) == 0) return $urandom_range(1, 4096);
        return $urandom_range(1, 48);
    endfunction

    task automatic random_phase(int bw, int bh, int n);
        write_reg(skyp_pkg::REG_BIN_WIDTH, bw);
        write_reg(skyp_pkg::REG_BIN_HEIGHT, bh);
        repeat (n) send_rect(rand_dim(), rand_dim());
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = skyp_pkg::REG_BIN_WIDTH;
        cfg_data = '0;
        burst_left = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset bins 1024 x 1024
        send_rect(0, 5);
        send_rect(5, 0);
        send_rect(4096, 1);
        send_rect(1, 4096);
        send_rect(1024, 1);
        send_rect(100, 50);
        send_rect(50, 100);
        send_rect(8, 1023);     // top lands exactly on bin height
        send_rect(1, 1);
        send_rect(8191, 8191);

        // width kept below 1024 so the right part stays low for the staircase
        random_phase(700, 1024, 270);
        random_phase(700, 4096, 270);
        random_phase(1, 1, 30);
        random_phase(700, 2048, 270);

        // staircase of 1-wide rects with rising heights fills the segment store
        write_reg(skyp_pkg::REG_BIN_WIDTH, 4096);
        write_reg(skyp_pkg::REG_BIN_HEIGHT, 4096);
        for (int k = 1; k <= 320; k++) send_rect(1, k);

        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        repeat (40) #100_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
